>>> design/a85dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85dec_pkg
// types, constants and helpers shared by the base-85 decoder modules
// ----------------------------------------------------------------------------
package a85dec_pkg;

    localparam logic [7:0]  FIRST_CHAR      = 8'h21;
    localparam logic [7:0]  LAST_CHAR       = 8'h75;
    localparam logic [31:0] BASE            = 32'd85;
    localparam logic [2:0]  GROUP_DIGITS    = 3'd5;
    localparam logic [2:0]  BYTES_PER_GROUP = 3'd4;

    // one queued job for the back end
    typedef struct packed {
        logic [31:0] value;   // accumulated group value before padding
        logic [2:0]  nbytes;  // results to emit, 1..4
        logic [2:0]  npad;    // pad digits to append, 0..3
        logic        bad;     // error result
        logic        last;    // belongs to the final input item
    } entry_t;

    // 85 to the power k, for k pad digits
    function automatic logic [31:0] pad_scale(input logic [2:0] k);
        logic [31:0] s;
        case (k)
            3'd0:    s = 32'd1;
            3'd1:    s = 32'd85;
            3'd2:    s = 32'd7225;
            3'd3:    s = 32'd614125;
            3'd4:    s = 32'd52200625;
            default: s = 32'd1;
        endcase
        return s;
    endfunction

endpackage

>>> design/a85dec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85dec_front
// accepts characters, checks range, accumulates digits and queues byte jobs
// ----------------------------------------------------------------------------
module a85dec_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] char_in
    input  logic                 s_tlast,   // end_of_input
    input  logic                 q_full,
    output logic                 push,
    output a85dec_pkg::entry_t   push_entry
);

    logic [31:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        aborted_reg, aborted_next;

    logic        accept;
    logic        char_ok;
    logic [7:0]  digit;
    logic [31:0] acc_sum;
    logic [2:0]  cnt_inc;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        char_ok = s_tdata inside {[a85dec_pkg::FIRST_CHAR:a85dec_pkg::LAST_CHAR]};
        digit   = s_tdata - a85dec_pkg::FIRST_CHAR;
        acc_sum = 32'(acc_reg * a85dec_pkg::BASE) + {24'd0, digit};
        cnt_inc = cnt_reg + 3'd1;

        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        aborted_next = aborted_reg;
        push         = 1'b0;
        push_entry   = '{value: acc_sum, nbytes: cnt_inc - 3'd1,
                         npad: a85dec_pkg::GROUP_DIGITS - cnt_inc,
                         bad: 1'b0, last: s_tlast};

        if (accept) begin
            if (aborted_reg) begin
                if (s_tlast) begin
                    aborted_next = 1'b0;
                    acc_next     = '0;
                    cnt_next     = '0;
                end
            end else if (!char_ok) begin
                aborted_next = !s_tlast;
                acc_next     = '0;
                cnt_next     = '0;
                push         = 1'b1;
                push_entry   = '{value: '0, nbytes: 3'd1, npad: 3'd0,
                                 bad: 1'b1, last: s_tlast};
            end else if (cnt_inc == a85dec_pkg::GROUP_DIGITS) begin
                acc_next = '0;
                cnt_next = '0;
                push     = 1'b1;
            end else if (s_tlast) begin
                acc_next = '0;
                cnt_next = '0;
                // a single trailing digit yields no bytes
                push     = (cnt_inc != 3'd1);
            end else begin
                acc_next = acc_sum;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            aborted_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            aborted_reg <= aborted_next;
        end
    end

endmodule

>>> design/a85dec_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85dec_queue
// short first-in first-out buffer of byte jobs between front and back end
// ----------------------------------------------------------------------------
module a85dec_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  a85dec_pkg::entry_t   push_entry,
    input  logic                 pop,
    output a85dec_pkg::entry_t   head,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    a85dec_pkg::entry_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/a85dec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85dec_back
// pads the group value and emits its bytes, most significant first
// ----------------------------------------------------------------------------
module a85dec_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  a85dec_pkg::entry_t   head,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] data_byte
    output logic                 m_tlast,   // run_last
    output logic [1:0]           m_tuser    // [0] bad_char, [1] stream_done
);

    logic        work_valid_reg, work_valid_next;
    logic [31:0] work_value_reg, work_value_next;
    logic [2:0]  work_cnt_reg, work_cnt_next;
    logic        work_bad_reg, work_bad_next;
    logic        work_last_reg, work_last_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_tlast_reg, out_tlast_next;
    logic [1:0]  out_user_reg, out_user_next;

    logic        out_free;
    logic        emit;
    logic        work_free;
    logic [31:0] padded;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = out_free && work_valid_reg;
    assign work_free = !work_valid_reg || (emit && work_cnt_reg == 3'd1);
    assign pop       = work_free && !q_empty;

    // pad digits of value 84: v*85^k + 85^k - 1, all modulo 2^32
    assign padded = 32'((head.value + 32'd1) * a85dec_pkg::pad_scale(head.npad)) - 32'd1;

    always_comb begin
        work_valid_next = work_valid_reg;
        work_value_next = work_value_reg;
        work_cnt_next   = work_cnt_reg;
        work_bad_next   = work_bad_reg;
        work_last_next  = work_last_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_tlast_next  = out_tlast_reg;
        out_user_next   = out_user_reg;

        if (emit) begin
            out_valid_next  = 1'b1;
            out_data_next   = work_value_reg[31:24];
            out_tlast_next  = (work_cnt_reg == 3'd1);
            out_user_next   = {work_last_reg, work_bad_reg};
            work_value_next = {work_value_reg[23:0], 8'd0};
            work_cnt_next   = work_cnt_reg - 3'd1;
        end

        if (work_free) begin
            work_valid_next = pop;
            if (pop) begin
                work_value_next = padded;
                work_cnt_next   = head.nbytes;
                work_bad_next   = head.bad;
                work_last_next  = head.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            work_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
            work_cnt_reg   <= work_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_value_reg <= work_value_next;
        work_bad_reg   <= work_bad_next;
        work_last_reg  <= work_last_next;
        out_data_reg   <= out_data_next;
        out_tlast_reg  <= out_tlast_next;
        out_user_reg   <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_tlast_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // an error result stands alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("error item not marked last");

    // error results carry a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("error item with nonzero data");

    // a loaded job always has bytes left
    assert property (@(posedge aclk) disable iff (!aresetn)
        work_valid_reg |-> work_cnt_reg != 3'd0 && work_cnt_reg <= a85dec_pkg::BYTES_PER_GROUP)
        else $error("job byte count out of range");
`endif

endmodule

>>> design/ascii85_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii85_decoder
// streaming base-85 decoder, one character in, up to four bytes out
// ----------------------------------------------------------------------------
// input channel s_*: one character per item in s_tdata, s_tlast on the final
//   character of a stream
// output channel m_*: one decoded byte per item in m_tdata; m_tuser[0] flags
//   an invalid character, m_tuser[1] marks items of the final input item,
//   m_tlast marks the last result caused by one input item
// each group of five characters gives four bytes; a short final group is
//   padded and gives one byte less than its character count
// an invalid character gives one error item and the rest of the stream up to
//   s_tlast is dropped
// an accepted item's job passes the queue, the work register and the output
//   register in turn; throughput: one character per cycle, set by the
//   one-byte-per-cycle output register; the job queue of QUEUE_DEPTH entries
//   absorbs stalls on m_tready and s_tready falls only when the queue is full
// reset clears the group, the queue and the output register; no clearing pass
// ----------------------------------------------------------------------------
module ascii85_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // [0] bad_char, [1] stream_done
);

    a85dec_pkg::entry_t push_entry;
    a85dec_pkg::entry_t head;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    a85dec_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    a85dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    a85dec_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming base-85 decoder
// ----------------------------------------------------------------------------
// a short list of hand-picked characters comes first: all-zero and all-'u'
// groups, final groups of one to four digits, invalid characters mid-stream
// and on the end marker, and input dropped after an error; after that come
// random streams, mostly well formed with a few broken ones and some noise
// every accepted character runs through a local decoder model, and each
// decoded item is compared field by field with the oldest pending one
// the sender works in bursts with random gaps, and the receiver stalls in
// changing patterns
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS = 225;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [7:0] PAD_DIGIT = a85dec_pkg::LAST_CHAR - a85dec_pkg::FIRST_CHAR;

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       run_last;
        logic       done;
    } out_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         fixed;
        int         nres;
        out_item_t  res;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    // decoder model state
    logic [31:0] grp_value = '0;
    logic [2:0]  grp_digits = '0;
    bit          skipping = 1'b0;

    out_item_t   decoded_fifo [$];
    stim_row_t   dir_rows [$];
    int          mismatch_cnt = 0;
    int          random_cnt = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          rcv_cycle = 0;

    // attributes of the item now on the input bus
    bit          row_fixed = 1'b0;
    int          row_nres = 0;
    out_item_t   row_res = '0;

    always #6 aclk = ~aclk;

    ascii85_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    function automatic int decode_char(input logic [7:0] ch, input logic eoi,
                                       output out_item_t res [4]);
        logic [31:0] v;
        int          n;
        n = 0;
        v = '0;
        for (int k = 0; k < 4; k++) res[k] = '0;
        if (skipping) begin
            if (eoi) begin
                skipping   = 1'b0;
                grp_value  = '0;
                grp_digits = '0;
            end
            return 0;
        end
        if (ch < a85dec_pkg::FIRST_CHAR || ch > a85dec_pkg::LAST_CHAR) begin
            grp_value  = '0;
            grp_digits = '0;
            skipping   = !eoi;
            res[0] = '{data: 8'h00, bad: 1'b1, run_last: 1'b1, done: eoi};
            return 1;
        end
        grp_value  = grp_value * a85dec_pkg::BASE + 32'(ch - a85dec_pkg::FIRST_CHAR);
        grp_digits = grp_digits + 3'd1;
        if (grp_digits == a85dec_pkg::GROUP_DIGITS) begin
            v = grp_value;
            n = int'(a85dec_pkg::BYTES_PER_GROUP);
        end else if (eoi) begin
            v = grp_value;
            for (int k = int'(grp_digits); k < int'(a85dec_pkg::GROUP_DIGITS); k++)
                v = v * a85dec_pkg::BASE + 32'(PAD_DIGIT);
            n = int'(grp_digits) - 1;
        end else begin
            return 0;
        end
        grp_value  = '0;
        grp_digits = '0;
        for (int k = 0; k < n; k++) begin
            res[k] = '{data: v[31 - 8 * k -: 8], bad: 1'b0, run_last: (k == n - 1),
                       done: eoi};
        end
        return n;
    endfunction

    function automatic stim_row_t mk_row(input logic [7:0] ch, input logic eoi,
                                         input bit fixed, input int nres,
                                         input logic done);
        stim_row_t r;
        r.ch    = ch;
        r.eoi   = eoi;
        r.fixed = fixed;
        r.nres  = nres;
        r.res   = '{data: 8'h00, bad: 1'b1, run_last: 1'b1, done: done};
        return r;
    endfunction

    function automatic logic [7:0] rand_digit();
        case ($urandom_range(0, 7))
            0:       return a85dec_pkg::FIRST_CHAR;
            1:       return a85dec_pkg::LAST_CHAR;
            default: return 8'($urandom_range(a85dec_pkg::FIRST_CHAR, a85dec_pkg::LAST_CHAR));
        endcase
    endfunction

    function automatic logic [7:0] rand_bad_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, a85dec_pkg::FIRST_CHAR - 1));
        return 8'($urandom_range(a85dec_pkg::LAST_CHAR + 1, 255));
    endfunction

    task automatic idle(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom_range(0, 1));
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic eoi, input bit fixed,
                             input int nres, input out_item_t res);
        if (burst_left == 0) begin
            idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        random_cnt++;
        @(negedge aclk);
        row_fixed = fixed;
        row_nres  = nres;
        row_res   = res;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_stream();
        int         len;
        int         bad_pos;
        int         kind;
        logic [7:0] ch;
        kind = $urandom_range(0, 9);
        len = (kind == 9) ? 5 * $urandom_range(1, 4) : $urandom_range(1, 22);
        bad_pos = (kind >= 6 && kind <= 7) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (kind == 8) ch = 8'($urandom_range(0, 255));
            else if (i == bad_pos) ch = rand_bad_char();
            else ch = rand_digit();
            send_char(ch, i == len - 1, 1'b0, 0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     want, got);
        end
    endtask

    // input side feeds the model, output side is checked against it
    always @(posedge aclk) begin
        out_item_t pred [4];
        out_item_t want;
        int        n;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                n = decode_char(s_tdata, s_tlast, pred);
                if (row_fixed) begin
                    if (row_nres != 0) decoded_fifo.push_back(row_res);
                end else begin
                    for (int k = 0; k < n; k++) decoded_fifo.push_back(pred[k]);
                end
            end
            if (m_tvalid && m_tready) begin
                if (decoded_fifo.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected item, expected none, actual %0h/%0b/%0b/%0b",
                             $time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
                end else begin
                    want = decoded_fifo.pop_front();
                    check_field("data_byte", want.data, m_tdata);
                    check_field("bad_char", 8'(want.bad), 8'(m_tuser[0]));
                    check_field("run_last", 8'(want.run_last), 8'(m_tlast));
                    check_field("stream_done", 8'(want.done), 8'(m_tuser[1]));
                end
            end
        end
    end

    // receiver stall pattern, stepping through four modes in turn
    always @(negedge aclk) begin
        rcv_cycle <= rcv_cycle + 1;
        case ((rcv_cycle / 97) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= (rcv_cycle % 5) != 0;
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (rcv_cycle % 16) < 4;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        stim_row_t r;
        // full groups, all-zero and wrapping all-'u'
        dir_rows.push_back(mk_row(a85dec_pkg::FIRST_CHAR, 1'b0, 1'b1, 0, 1'b0));
        repeat (4) dir_rows.push_back(mk_row(a85dec_pkg::FIRST_CHAR, 1'b0, 1'b0, 0, 1'b0));
        repeat (4) dir_rows.push_back(mk_row(a85dec_pkg::LAST_CHAR, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row(a85dec_pkg::LAST_CHAR, 1'b1, 1'b0, 0, 1'b0));
        // error mid-stream, then dropped up to the end marker
        dir_rows.push_back(mk_row(8'h00, 1'b0, 1'b1, 1, 1'b0));
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 1'b1, 0, 1'b0));
        // final groups of one to four digits
        dir_rows.push_back(mk_row(a85dec_pkg::LAST_CHAR, 1'b1, 1'b1, 0, 1'b0));
        dir_rows.push_back(mk_row("9", 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("j", 1'b1, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("F", 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("c", 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("<", 1'b1, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("8", 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("A", 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("R", 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(mk_row("b", 1'b1, 1'b0, 0, 1'b0));
        // 'z' is invalid here, error on the end marker
        dir_rows.push_back(mk_row("z", 1'b1, 1'b1, 1, 1'b1));
        dir_rows.push_back(mk_row(a85dec_pkg::LAST_CHAR + 8'd1, 1'b0, 1'b1, 1, 1'b0));
        dir_rows.push_back(mk_row(a85dec_pkg::FIRST_CHAR - 8'd1, 1'b1, 1'b1, 0, 1'b0));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_char(r.ch, r.eoi, r.fixed, r.nres, r.res);
        end
        random_cnt = 0;
        while (random_cnt < RANDOM_ITEMS) send_stream();
        idle(1);

        while (decoded_fifo.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
design/a85dec_pkg.sv
design/a85dec_front.sv
design/a85dec_queue.sv
design/a85dec_back.sv
design/ascii85_decoder.sv
tb/sv/tb_top.sv
